// ===== src/refla_pkg.sv =====
// shared types and constants of the reserved-entry free-list allocator
// no dependencies; used by every module under src

package refla_pkg;

  // ordinary entries on the free list; the two reserved entries follow them
  localparam int Size = 16;

  // fixed field widths of a transaction
  localparam int IdxW = 5;
  localparam int CntOutW = 5;

  // internal widths derived from the list depth
  localparam int PtrW = (Size > 1) ? $clog2(Size) : 1;
  localparam int CntW = $clog2(Size + 1);

  // reserved entry indices
  localparam logic [IdxW-1:0] WbIdx = IdxW'(Size);
  localparam logic [IdxW-1:0] LocalIdx = IdxW'(Size + 1);

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  // request types
  localparam logic [1:0] REQ_NORMAL = 2'd0;
  localparam logic [1:0] REQ_WRITEBACK = 2'd1;
  localparam logic [1:0] REQ_LOCAL = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  typedef struct packed {
    logic            action;
    logic [1:0]      request_type;
    logic [IdxW-1:0] entry_index;
  } req_item_t;

  typedef struct packed {
    logic [IdxW-1:0]    granted_index;
    logic [1:0]         status;
    logic [CntOutW-1:0] free_count;
    logic               writeback_reserved_free;
    logic               local_reserved_free;
  } rsp_item_t;

endpackage

// ===== src/refla_core.sv =====
// free list storage, pointers, reserved flags and the per-transaction decision
// depends on refla_pkg

module refla_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  refla_pkg::req_item_t item,
  output refla_pkg::rsp_item_t result
);

  logic [refla_pkg::IdxW-1:0] fifo [refla_pkg::Size];
  logic [refla_pkg::PtrW-1:0] head;
  logic [refla_pkg::PtrW-1:0] tail;
  logic [refla_pkg::CntW-1:0] count;
  logic                       wb_free;
  logic                       local_free;

  logic [refla_pkg::PtrW-1:0] head_next;
  logic [refla_pkg::PtrW-1:0] tail_next;
  logic [refla_pkg::CntW-1:0] count_next;
  logic                       wb_free_next;
  logic                       local_free_next;
  logic                       push;
  logic [refla_pkg::IdxW-1:0] granted;
  logic [1:0]                 status;

  function automatic logic [refla_pkg::PtrW-1:0] ptr_inc(input logic [refla_pkg::PtrW-1:0] p);
    logic [refla_pkg::PtrW-1:0] r;
    if (p == refla_pkg::PtrW'(refla_pkg::Size - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    wb_free_next    = wb_free;
    local_free_next = local_free;
    push            = 1'b0;
    granted         = '0;
    status          = refla_pkg::STATUS_OK;
    if (item.action == refla_pkg::ACT_ALLOC) begin
      if (count != '0) begin
        granted    = fifo[head];
        head_next  = ptr_inc(head);
        count_next = count - 1'b1;
      end else if (item.request_type == refla_pkg::REQ_WRITEBACK && wb_free) begin
        wb_free_next = 1'b0;
        granted      = refla_pkg::WbIdx;
      end else if (item.request_type == refla_pkg::REQ_LOCAL && local_free) begin
        local_free_next = 1'b0;
        granted         = refla_pkg::LocalIdx;
      end else begin
        status = refla_pkg::STATUS_REFUSED;
      end
    end else begin
      if (item.entry_index == refla_pkg::WbIdx) begin
        wb_free_next = 1'b1;
      end else if (item.entry_index == refla_pkg::LocalIdx) begin
        local_free_next = 1'b1;
      end else if (item.entry_index > refla_pkg::LocalIdx) begin
        status = refla_pkg::STATUS_BAD;
      end else if (count == refla_pkg::CntW'(refla_pkg::Size)) begin
        status = refla_pkg::STATUS_BAD;
      end else begin
        push       = 1'b1;
        tail_next  = ptr_inc(tail);
        count_next = count + 1'b1;
      end
    end
  end

  always_comb begin
    result.granted_index           = granted;
    result.status                  = status;
    result.free_count              = refla_pkg::CntOutW'(count_next);
    result.writeback_reserved_free = wb_free_next;
    result.local_reserved_free     = local_free_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= refla_pkg::CntW'(refla_pkg::Size);
      wb_free    <= 1'b1;
      local_free <= 1'b1;
    end else if (step) begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      wb_free    <= wb_free_next;
      local_free <= local_free_next;
    end
  end

  // list storage comes out of reset holding the ordinary indices in order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < refla_pkg::Size; i++) begin
        fifo[i] <= refla_pkg::IdxW'(i);
      end
    end else if (step && push) begin
      fifo[tail] <= item.entry_index;
    end
  end

endmodule

// ===== src/reserved_entry_free_list_allocator.sv =====
// top level of the reserved-entry free-list allocator
// throughput: one transaction per cycle while responses are taken; the free
//   list update sits between the request register and the response
//   register
// reset: list holds the ordinary indices in order, both reserved entries free
// depends on refla_pkg and refla_core

module reserved_entry_free_list_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  refla_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output refla_pkg::rsp_item_t rsp
);

  // request register
  logic                 hold_valid;
  refla_pkg::req_item_t hold;

  // the held transaction moves on once the response slot is free or draining
  logic                 advance;
  refla_pkg::rsp_item_t result;

  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  // payload captured without reset
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  // state of the list changes only when a transaction goes through
  refla_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold),
    .result (result)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

// ===== src/refla_checker.sv =====
// port-level checks for the reserved-entry free-list allocator
// depends on refla_pkg; bound to reserved_entry_free_list_allocator

module refla_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input refla_pkg::rsp_item_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // no response straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a refusal only happens with an empty list and no grant
  a_refuse_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == refla_pkg::STATUS_REFUSED
      |-> rsp.free_count == '0 && rsp.granted_index == '0)
    else $error("refusal with entries on the list");

  // granting the writeback entry leaves it taken
  a_wb_taken: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted_index == refla_pkg::WbIdx
      |-> !rsp.writeback_reserved_free && rsp.free_count == '0)
    else $error("writeback entry still free after grant");

  // count never exceeds list depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.free_count <= refla_pkg::CntOutW'(refla_pkg::Size))
    else $error("free count out of range");

endmodule

bind reserved_entry_free_list_allocator refla_checker u_refla_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== tb/reserved_entry_free_list_allocator_tb.sv =====
// self-checking testbench for reserved_entry_free_list_allocator
// holds its own free-list predictor, a queue-fed driver and a response monitor
// depends on refla_pkg and the allocator top level under src

module reserved_entry_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // request type code that the block does not use; it behaves as a normal request
  localparam logic [1:0] ReqSpare = 2'd3;

  // length of the long receiver hold-off used to fill the pipeline
  localparam int HoldCycles = 300;

  // cap on printed mismatch lines so a broken block cannot flood the log
  localparam int ReportCap = 200;

  // predictor state: the ordinary free list plus both reserved flags
  typedef struct {
    logic [refla_pkg::IdxW-1:0] slot [refla_pkg::Size];
    int unsigned                head;
    int unsigned                tail;
    int unsigned                count;
    logic                       wb_free;
    logic                       local_free;
  } list_state_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  refla_pkg::req_item_t req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  refla_pkg::rsp_item_t rsp;

  // transactions waiting to be offered, and responses still owed by the block
  refla_pkg::req_item_t pending_requests [$];
  refla_pkg::rsp_item_t expected_responses [$];

  // list as seen at request acceptance, and the copy the stimulus planner walks
  list_state_t predicted_list;
  list_state_t planned_list;

  // entries the planner believes are currently handed out
  logic [refla_pkg::IdxW-1:0] held_entries [$];

  int sender_idle_pct = 0;
  int rsp_stall_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;

  int mismatch_count = 0;
  int report_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int backpressure_cycles = 0;
  int refused_seen = 0;
  int bad_seen = 0;

  reserved_entry_free_list_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // free-list predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= refla_pkg::Size) ? 0 : p + 1;
  endfunction

  // list straight out of reset: ordinary indices in order, both reserved free
  function automatic list_state_t fresh_list();
    list_state_t st;
    for (int i = 0; i < refla_pkg::Size; i++) st.slot[i] = refla_pkg::IdxW'(i);
    st.head = 0;
    st.tail = 0;
    st.count = refla_pkg::Size;
    st.wb_free = 1'b1;
    st.local_free = 1'b1;
    return st;
  endfunction

  // applies one request transaction to the list and returns the response it causes
  function automatic refla_pkg::rsp_item_t apply_request(inout list_state_t st,
                                                         input refla_pkg::req_item_t r);
    refla_pkg::rsp_item_t o;
    o = '0;
    o.status = refla_pkg::STATUS_OK;
    if (r.action == refla_pkg::ACT_ALLOC) begin
      // ordinary entries always go first; reserved ones only once the list is dry
      if (st.count > 0) begin
        o.granted_index = st.slot[st.head];
        st.head = next_slot(st.head);
        st.count--;
      end else if (r.request_type == refla_pkg::REQ_WRITEBACK && st.wb_free) begin
        st.wb_free = 1'b0;
        o.granted_index = refla_pkg::WbIdx;
      end else if (r.request_type == refla_pkg::REQ_LOCAL && st.local_free) begin
        st.local_free = 1'b0;
        o.granted_index = refla_pkg::LocalIdx;
      end else begin
        o.status = refla_pkg::STATUS_REFUSED;
      end
    end else begin
      if (r.entry_index == refla_pkg::WbIdx) begin
        st.wb_free = 1'b1;
      end else if (r.entry_index == refla_pkg::LocalIdx) begin
        st.local_free = 1'b1;
      end else if (r.entry_index > refla_pkg::LocalIdx) begin
        o.status = refla_pkg::STATUS_BAD;
      end else if (st.count >= refla_pkg::Size) begin
        // list already full: the free is dropped
        o.status = refla_pkg::STATUS_BAD;
      end else begin
        // duplicates are not caught, the index goes on the tail as given
        st.slot[st.tail] = r.entry_index;
        st.tail = next_slot(st.tail);
        st.count++;
      end
    end
    o.free_count = refla_pkg::CntOutW'(st.count);
    o.writeback_reserved_free = st.wb_free;
    o.local_reserved_free = st.local_free;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------

  function automatic refla_pkg::req_item_t make_req(logic act, logic [1:0] rtype, int idx);
    refla_pkg::req_item_t r;
    r.action = act;
    r.request_type = rtype;
    r.entry_index = refla_pkg::IdxW'(idx);
    return r;
  endfunction

  // walks the planner copy of the list so later frees can target held entries
  task automatic queue_request(refla_pkg::req_item_t r);
    refla_pkg::rsp_item_t o;
    o = apply_request(planned_list, r);
    if (r.action == refla_pkg::ACT_ALLOC && o.status == refla_pkg::STATUS_OK) begin
      held_entries.insert(held_entries.size(), o.granted_index);
    end
    pending_requests.insert(pending_requests.size(), r);
  endtask

  // mostly well-formed traffic: allocates and frees of held entries, some noise
  task automatic queue_random_item(int alloc_pct);
    int roll;
    int k;
    logic [refla_pkg::IdxW-1:0] idx;
    roll = $urandom_range(99);
    if (roll < 10) begin
      // noise free: any index, including out of range and duplicates
      idx = refla_pkg::IdxW'($urandom_range(31));
      k = -1;
      for (int j = 0; j < held_entries.size(); j++) begin
        if (held_entries[j] == idx && k < 0) k = j;
      end
      if (k >= 0) held_entries.delete(k);
      queue_request(make_req(refla_pkg::ACT_FREE, 2'($urandom_range(3)), idx));
    end else if ($urandom_range(99) < alloc_pct || held_entries.size() == 0) begin
      queue_request(make_req(refla_pkg::ACT_ALLOC, 2'($urandom_range(3)),
                             $urandom_range(31)));
    end else begin
      // return a held entry, picked at random so the list order gets shuffled
      k = $urandom_range(held_entries.size() - 1);
      idx = held_entries[k];
      held_entries.delete(k);
      queue_request(make_req(refla_pkg::ACT_FREE, 2'($urandom_range(3)), idx));
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_responses.size() > 0) @(negedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int n);
    int alloc_pct;
    sender_idle_pct = idle;
    rsp_stall_pct = stall;
    alloc_pct = 50;
    for (int i = 0; i < n; i++) begin
      // bursts with their own allocate bias so the list both drains and refills
      if (i % 30 == 0) begin
        case ($urandom_range(3))
          0: alloc_pct = 20;
          1: alloc_pct = 50;
          2: alloc_pct = 75;
          default: alloc_pct = 92;
        endcase
      end
      queue_random_item(alloc_pct);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the head of the pending queue, holds it until accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) pending_requests.delete(0);
      // a transaction still waiting keeps valid and payload as they are
      if (!(req_valid && !req_ready)) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_valid <= 1'b1;
          req <= pending_requests[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long counted hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HoldCycles;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on request acceptance, checks on response acceptance
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (report_count < ReportCap) begin
        report_count++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    refla_pkg::rsp_item_t due;
    if (!rst) begin
      // predict first so even a response accepted together with its request would find its expectation
      if (req_valid && req_ready) begin
        expected_responses.insert(expected_responses.size(),
                                  apply_request(predicted_list, req));
        accepted_count++;
      end
      if (req_valid && !req_ready) backpressure_cycles++;
      if (rsp_valid && rsp_ready) begin
        if (expected_responses.size() == 0) begin
          mismatch_count++;
          if (report_count < ReportCap) begin
            report_count++;
            $display("%0t ns: unexpected response, expected none, got %p", $time, rsp);
          end
        end else begin
          due = expected_responses[0];
          expected_responses.delete(0);
          checked_count++;
          if (due.status == refla_pkg::STATUS_REFUSED) refused_seen++;
          if (due.status == refla_pkg::STATUS_BAD) bad_seen++;
          check_field("granted_index", due.granted_index, rsp.granted_index);
          check_field("status", due.status, rsp.status);
          check_field("free_count", due.free_count, rsp.free_count);
          check_field("writeback_reserved_free", due.writeback_reserved_free,
                      rsp.writeback_reserved_free);
          check_field("local_reserved_free", due.local_reserved_free,
                      rsp.local_reserved_free);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    predicted_list = fresh_list();
    planned_list = fresh_list();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: frees against a full list and out-of-range indices
    // reserved already free
    queue_request(make_req(refla_pkg::ACT_FREE, ReqSpare, refla_pkg::WbIdx));
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_NORMAL, refla_pkg::LocalIdx));
    // just past the top
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_LOCAL,
                           refla_pkg::LocalIdx + 1));
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_WRITEBACK, 31));
    // list full, dropped
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_NORMAL, 0));
    // drain the list, ignored index at both extremes, every request type
    for (int i = 0; i < refla_pkg::Size; i++) begin
      queue_request(make_req(refla_pkg::ACT_ALLOC, 2'(i % 4), (i % 2) ? 31 : 0));
    end
    // empty list: normal and spare refused, each reserved entry once then refused
    queue_request(make_req(refla_pkg::ACT_ALLOC, refla_pkg::REQ_NORMAL, 0));
    queue_request(make_req(refla_pkg::ACT_ALLOC, ReqSpare, 31));
    queue_request(make_req(refla_pkg::ACT_ALLOC, refla_pkg::REQ_WRITEBACK, 0));
    queue_request(make_req(refla_pkg::ACT_ALLOC, refla_pkg::REQ_WRITEBACK, 0));
    queue_request(make_req(refla_pkg::ACT_ALLOC, refla_pkg::REQ_LOCAL, 0));
    queue_request(make_req(refla_pkg::ACT_ALLOC, refla_pkg::REQ_LOCAL, 0));
    // duplicate ordinary free goes on the list twice, then reserved entries return
    queue_request(make_req(refla_pkg::ACT_FREE, ReqSpare, refla_pkg::Size - 1));
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_NORMAL, refla_pkg::Size - 1));
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_NORMAL, refla_pkg::WbIdx));
    queue_request(make_req(refla_pkg::ACT_FREE, refla_pkg::REQ_NORMAL, refla_pkg::LocalIdx));
    // the planner's held set is stale after the directed part; resync from the list
    held_entries.delete();
    for (int i = 0; i < refla_pkg::Size - 2; i++) begin
      held_entries.insert(held_entries.size(), refla_pkg::IdxW'(i));
    end
    wait_drained();

    run_phase(0, 0, 150);
    run_phase(67, 0, 150);
    run_phase(0, 67, 150);
    run_phase(20, 20, 150);

    // pressure: receiver holds off while the sender keeps offering
    sender_idle_pct = 0;
    rsp_stall_pct = 0;
    for (int i = 0; i < 80; i++) queue_random_item(60);
    hold_request = 1'b1;
    @(negedge clk);
    hold_request = 1'b0;
    wait_drained();

    // let any stray response show itself before the verdict
    repeat (10) @(negedge clk);

    $display("covered %0d request transactions, %0d responses checked, %0d refused, %0d bad",
             accepted_count, checked_count, refused_seen, bad_seen);
    $display("idling phases on both sides and a long hold-off with %0d stalled request cycles",
             backpressure_cycles);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #500us;
    $display("timeout with %0d responses still owed", expected_responses.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
